// ===== hdl/cqp_pkg.sv =====
// ----------------------------------------------------------------------------
// cqp_pkg
// Shared constants, command codes and index helpers for the circular queue.
// ----------------------------------------------------------------------------
package cqp_pkg;

   localparam int MAX_DEPTH  = 1024;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(MAX_DEPTH);
   localparam int CAP_W      = $clog2(MAX_DEPTH + 1);

   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [CAP_W-1:0]      cap_type;
   typedef logic [DATA_WIDTH-1:0] word_type;

   localparam logic [1:0] CMD_ENQ   = 2'd0;
   localparam logic [1:0] CMD_DEQ   = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam cap_type  CAP_MAX   = CAP_W'(MAX_DEPTH);
   localparam cap_type  CAP_MIN   = CAP_W'(1);
   localparam word_type WORD_ONES = '1;

   // next slot round the ring, wrapping at the programmed capacity
   function automatic addr_type advance(input addr_type idx, input cap_type cap);
      cap_type nxt;
      nxt = cap_type'(idx) + CAP_W'(1);
      return (nxt >= cap) ? '0 : nxt[ADDR_W-1:0];
   endfunction

endpackage

// ===== hdl/cqp_if.sv =====
// ----------------------------------------------------------------------------
// cqp channel interfaces
// Request, response and control-register write channels, valid/ready style.
// ----------------------------------------------------------------------------
interface cqp_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             cmd;
   logic signed [cqp_pkg::DATA_WIDTH-1:0]  value;
   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface cqp_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   ok;
   logic signed [cqp_pkg::DATA_WIDTH-1:0]  front_value;
   logic signed [cqp_pkg::DATA_WIDTH-1:0]  rear_value;
   logic                                   is_empty;
   logic                                   is_full;
   modport source (output valid, output ok, output front_value, output rear_value,
                   output is_empty, output is_full, input ready);
   modport sink   (input valid, input ok, input front_value, input rear_value,
                   input is_empty, input is_full, output ready);
endinterface

interface cqp_csr_if;
   logic                          valid;
   logic                          ready;
   logic [cqp_pkg::CAP_W-1:0]     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/cqp_ram.sv =====
// ----------------------------------------------------------------------------
// cqp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cqp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/circular_queue_with_peek.sv =====
// ----------------------------------------------------------------------------
// circular_queue_with_peek
// Ring-buffer FIFO of programmable capacity reporting both ends on each op.
// ----------------------------------------------------------------------------
// usage
//   req_ch  : one transaction per operation, cmd enqueue / dequeue / query
//             (unused code behaves as query), value stored on enqueue
//   rsp_ch  : exactly one transaction per request, in order: ok flag, oldest
//             and newest entries (all ones when empty), empty and full flags,
//             all as they stand after the operation
//   csr_ch  : capacity write, always ready; ignored unless the queue is empty,
//             saturated to 1..MAX_DEPTH, rewinds both indices to slot zero
// timing
//   in the accept cycle a request updates the indices and issues the single
//   ram access (write on enqueue, read of the new head on dequeue); in the
//   cycle after, the done state collects the ram read data and forms the
//   response once the output register is free
//   a new request is accepted only after the previous one has completed
//   a response waiting on rsp_ch does not block the next request from being
//   accepted; only its completion stalls until the output register is free
// reset
//   synchronous, active high: queue empty, indices zero, capacity MAX_DEPTH,
//   no response pending; ram contents are not cleared and need no sweep
// ----------------------------------------------------------------------------
module circular_queue_with_peek (
   input  logic      clock,
   input  logic      reset,
   cqp_req_if.sink   req_ch,
   cqp_rsp_if.source rsp_ch,
   cqp_csr_if.sink   csr_ch
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;

   // queue bookkeeping
   cqp_pkg::addr_type head_ff, head_in;
   cqp_pkg::addr_type tail_ff, tail_in;
   logic              empty_ff, empty_in;
   cqp_pkg::cap_type  cap_ff, cap_in;

   // cached copies of both ends
   cqp_pkg::word_type front_ff, front_in;
   cqp_pkg::word_type rear_ff, rear_in;

   // per-transaction info carried into the completion cycle
   logic              ok_ff, ok_in;
   logic              need_rd_ff, need_rd_in;

   // response output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   cqp_pkg::word_type rsp_front_ff, rsp_front_in;
   cqp_pkg::word_type rsp_rear_ff, rsp_rear_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_full_ff, rsp_full_in;

   // ram side
   logic              ram_wr_en;
   cqp_pkg::addr_type ram_wr_addr;
   logic              ram_rd_en;
   cqp_pkg::word_type ram_rd_data;

   logic              req_fire;
   logic              csr_fire;
   logic              rsp_free;
   cqp_pkg::addr_type head_adv;
   cqp_pkg::addr_type tail_adv;
   logic              full_now;
   cqp_pkg::cap_type  csr_sat;
   cqp_pkg::word_type front_cur;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign head_adv = cqp_pkg::advance(head_ff, cap_ff);
   assign tail_adv = cqp_pkg::advance(tail_ff, cap_ff);
   assign full_now = !empty_ff && (tail_adv == head_ff);

   // capacity write saturates into the legal range
   always_comb begin
      if (csr_ch.data < cqp_pkg::CAP_MIN) begin
         csr_sat = cqp_pkg::CAP_MIN;
      end else if (csr_ch.data > cqp_pkg::CAP_MAX) begin
         csr_sat = cqp_pkg::CAP_MAX;
      end else begin
         csr_sat = csr_ch.data;
      end
   end

   // front after the operation: freshly read head or the cached copy
   assign front_cur = need_rd_ff ? ram_rd_data : front_ff;

   // ram accesses are issued in the accept cycle only
   assign ram_wr_en   = req_fire && (req_ch.cmd == cqp_pkg::CMD_ENQ) && !full_now;
   assign ram_wr_addr = empty_ff ? '0 : tail_adv;
   assign ram_rd_en   = req_fire && (req_ch.cmd == cqp_pkg::CMD_DEQ) && !empty_ff &&
                        (head_ff != tail_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      empty_in     = empty_ff;
      cap_in       = cap_ff;
      front_in     = front_ff;
      rear_in      = rear_ff;
      ok_in        = ok_ff;
      need_rd_in   = need_rd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_front_in = rsp_front_ff;
      rsp_rear_in  = rsp_rear_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_full_in  = rsp_full_ff;

      // output register drains when taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      // capacity only changes while empty; block is idle by contract
      if (csr_fire && empty_ff) begin
         cap_in  = csr_sat;
         head_in = '0;
         tail_in = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ok_in      = 1'b1;
               need_rd_in = ram_rd_en;
               case (req_ch.cmd)
                  cqp_pkg::CMD_ENQ: begin
                     if (full_now) begin
                        ok_in = 1'b0;
                     end else begin
                        rear_in = req_ch.value;
                        if (empty_ff) begin
                           // first entry lands in slot zero
                           head_in  = '0;
                           tail_in  = '0;
                           empty_in = 1'b0;
                           front_in = req_ch.value;
                        end else begin
                           tail_in = tail_adv;
                        end
                     end
                  end
                  cqp_pkg::CMD_DEQ: begin
                     if (empty_ff) begin
                        ok_in = 1'b0;
                     end else if (head_ff == tail_ff) begin
                        // last entry removed
                        empty_in = 1'b1;
                        head_in  = '0;
                        tail_in  = '0;
                     end else begin
                        head_in = head_adv;
                     end
                  end
                  default: begin
                  end
               endcase
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               front_in     = front_cur;
               need_rd_in   = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_front_in = empty_ff ? cqp_pkg::WORD_ONES : front_cur;
               rsp_rear_in  = empty_ff ? cqp_pkg::WORD_ONES : rear_ff;
               rsp_empty_in = empty_ff;
               rsp_full_in  = full_now;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         cap_ff       <= cqp_pkg::CAP_MAX;
         need_rd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         cap_ff       <= cap_in;
         need_rd_ff   <= need_rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload, no reset needed
      front_ff     <= front_in;
      rear_ff      <= rear_in;
      ok_ff        <= ok_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_front_ff <= rsp_front_in;
      rsp_rear_ff  <= rsp_rear_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_full_ff  <= rsp_full_in;
   end

   cqp_ram #(
      .WIDTH (cqp_pkg::DATA_WIDTH),
      .DEPTH (cqp_pkg::MAX_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_ch.value),
      .rd_en   (ram_rd_en),
      .rd_addr (head_adv),
      .rd_data (ram_rd_data)
   );

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.ok          = rsp_ok_ff;
   assign rsp_ch.front_value = rsp_front_ff;
   assign rsp_ch.rear_value  = rsp_rear_ff;
   assign rsp_ch.is_empty    = rsp_empty_ff;
   assign rsp_ch.is_full     = rsp_full_ff;

endmodule

// ===== hdl/cqp_checker.sv =====
// ----------------------------------------------------------------------------
// cqp_checker
// Port-level checks for the circular queue, bound to the top level.
// ----------------------------------------------------------------------------
module cqp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cqp_pkg::DATA_WIDTH-1:0] rsp_front_value,
   input logic [cqp_pkg::DATA_WIDTH-1:0] rsp_rear_value,
   input logic                          rsp_is_empty,
   input logic                          rsp_is_full
);

   // empty queue reports all ones at both ends
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |->
         (rsp_front_value == cqp_pkg::WORD_ONES) && (rsp_rear_value == cqp_pkg::WORD_ONES))
      else $error("empty response with live end values");

   // capacity is at least one, so empty and full never coincide
   a_not_empty_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_empty && rsp_is_full))
      else $error("response both empty and full");

   // one request in flight: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_front_value))
      else $error("stalled response changed");

endmodule

bind circular_queue_with_peek cqp_checker u_cqp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_front_value (rsp_ch.front_value),
   .rsp_rear_value  (rsp_ch.rear_value),
   .rsp_is_empty    (rsp_ch.is_empty),
   .rsp_is_full     (rsp_ch.is_full)
);
